FILE: design/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and codes for the time ordered event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

	localparam int CAPACITY_DEF  = 16;
	localparam int TIME_BITS_DEF = 32;
	localparam int TAG_BITS_DEF  = 16;

	localparam int ACTION_BITS = 2;
	localparam int STATUS_BITS = 2;

	localparam logic [ACTION_BITS-1:0] ACT_ENQUEUE = 2'd0;
	localparam logic [ACTION_BITS-1:0] ACT_DEQUEUE = 2'd1;
	localparam logic [ACTION_BITS-1:0] ACT_PEEK    = 2'd2;

	localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

FILE: design/teq_if.sv
// ----------------------------------------------------------------------------
// teq_req_if / teq_rsp_if
// Valid/ready channels carrying request and response words of the queue.
// ----------------------------------------------------------------------------
interface teq_req_if #(
	parameter int TIME_BITS = teq_pkg::TIME_BITS_DEF,
	parameter int TAG_BITS  = teq_pkg::TAG_BITS_DEF
);
	logic                                 valid;
	logic                                 ready;
	logic [teq_pkg::ACTION_BITS-1:0]      action;
	logic [TIME_BITS-1:0]                 event_time;
	logic [TAG_BITS-1:0]                  event_tag;

	modport source (output valid, action, event_time, event_tag, input ready);
	modport sink   (input valid, action, event_time, event_tag, output ready);
endinterface

interface teq_rsp_if #(
	parameter int TIME_BITS = teq_pkg::TIME_BITS_DEF,
	parameter int TAG_BITS  = teq_pkg::TAG_BITS_DEF,
	parameter int OCC_BITS  = $clog2(teq_pkg::CAPACITY_DEF + 1)
);
	logic                                 valid;
	logic                                 ready;
	logic [teq_pkg::STATUS_BITS-1:0]      status;
	logic [TIME_BITS-1:0]                 head_time;
	logic [TAG_BITS-1:0]                  head_tag;
	logic [OCC_BITS-1:0]                  occupancy;

	modport source (output valid, status, head_time, head_tag, occupancy, input ready);
	modport sink   (input valid, status, head_time, head_tag, occupancy, output ready);
endinterface

FILE: design/teq_cell.sv
// ----------------------------------------------------------------------------
// teq_cell
// One slot of the sorted chain: holds an entry, shifts up on insert, down on
// removal of the head.
// ----------------------------------------------------------------------------
module teq_cell #(
	parameter int TIME_BITS = teq_pkg::TIME_BITS_DEF,
	parameter int TAG_BITS  = teq_pkg::TAG_BITS_DEF
) (
	input  logic                 clk,
	input  teq_pkg::cell_ctl_t   ctl,
	input  logic                 occupied,
	input  logic [TIME_BITS-1:0] new_time,
	input  logic [TAG_BITS-1:0]  new_tag,
	input  logic                 left_after,
	input  logic [TIME_BITS-1:0] left_time,
	input  logic [TAG_BITS-1:0]  left_tag,
	input  logic [TIME_BITS-1:0] right_time,
	input  logic [TAG_BITS-1:0]  right_tag,
	output logic                 after,
	output logic [TIME_BITS-1:0] time_q,
	output logic [TAG_BITS-1:0]  tag_q
);

	// new word lands at or before this slot
	assign after = !occupied || (new_time < time_q);

	always_ff @(posedge clk) begin
		if (ctl.ins && after) begin
			if (left_after) begin
				time_q <= left_time;
				tag_q  <= left_tag;
			end else begin
				time_q <= new_time;
				tag_q  <= new_tag;
			end
		end else if (ctl.del) begin
			time_q <= right_time;
			tag_q  <= right_tag;
		end
	end

endmodule

FILE: design/time_ordered_event_queue.sv
// ----------------------------------------------------------------------------
// time_ordered_event_queue
// Bounded priority queue of events sorted by time, built as a chain of cells.
// ----------------------------------------------------------------------------
// Response valid is registered and rises in the cycle after a request is accepted.
// Throughput: 1 word per cycle; every cell compares and shifts in parallel.
// Stalls only while a response waits and the sink holds ready low.
// Reset: arst_n clears the entry count and response valid; slots hold
// undefined values until written.
module time_ordered_event_queue #(
	parameter int CAPACITY  = teq_pkg::CAPACITY_DEF,
	parameter int TIME_BITS = teq_pkg::TIME_BITS_DEF,
	parameter int TAG_BITS  = teq_pkg::TAG_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	teq_req_if.sink   req,
	teq_rsp_if.source rsp
);

	localparam int OCC_BITS = $clog2(CAPACITY + 1);

	logic [OCC_BITS-1:0]  count_q;
	logic                 rsp_valid_q;
	logic [teq_pkg::STATUS_BITS-1:0] status_q;
	logic [TIME_BITS-1:0] head_time_q;
	logic [TAG_BITS-1:0]  head_tag_q;

	logic                 acc;
	logic                 empty;
	logic                 full;
	teq_pkg::cell_ctl_t   ctl;

	logic [TIME_BITS-1:0] time_c   [CAPACITY];
	logic [TAG_BITS-1:0]  tag_c    [CAPACITY];
	logic                 after_c  [CAPACITY];
	logic                 l_after  [CAPACITY];
	logic [TIME_BITS-1:0] l_time   [CAPACITY];
	logic [TAG_BITS-1:0]  l_tag    [CAPACITY];
	logic [TIME_BITS-1:0] r_time   [CAPACITY];
	logic [TAG_BITS-1:0]  r_tag    [CAPACITY];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign empty     = (count_q == '0);
	assign full      = (count_q == OCC_BITS'(CAPACITY));

	assign ctl.ins = acc && (req.action == teq_pkg::ACT_ENQUEUE) && !full;
	assign ctl.del = acc && (req.action == teq_pkg::ACT_DEQUEUE) && !empty;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign l_after[g] = 1'b0;
			assign l_time[g]  = '0;
			assign l_tag[g]   = '0;
		end else begin : g_mid
			assign l_after[g] = after_c[g-1];
			assign l_time[g]  = time_c[g-1];
			assign l_tag[g]   = tag_c[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign r_time[g] = '0;
			assign r_tag[g]  = '0;
		end else begin : g_inner
			assign r_time[g] = time_c[g+1];
			assign r_tag[g]  = tag_c[g+1];
		end

		teq_cell #(
			.TIME_BITS (TIME_BITS),
			.TAG_BITS  (TAG_BITS)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (OCC_BITS'(g) < count_q),
			.new_time   (req.event_time),
			.new_tag    (req.event_tag),
			.left_after (l_after[g]),
			.left_time  (l_time[g]),
			.left_tag   (l_tag[g]),
			.right_time (r_time[g]),
			.right_tag  (r_tag[g]),
			.after      (after_c[g]),
			.time_q     (time_c[g]),
			.tag_q      (tag_c[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.ins) begin
				count_q <= count_q + OCC_BITS'(1);
			end else if (ctl.del) begin
				count_q <= count_q - OCC_BITS'(1);
			end
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q    <= teq_pkg::ST_OK;
			head_time_q <= '0;
			head_tag_q  <= '0;
			unique case (req.action)
				teq_pkg::ACT_ENQUEUE: begin
					if (full) begin
						status_q <= teq_pkg::ST_FULL;
					end
				end
				teq_pkg::ACT_DEQUEUE, teq_pkg::ACT_PEEK: begin
					if (empty) begin
						status_q <= teq_pkg::ST_EMPTY;
					end else begin
						head_time_q <= time_c[0];
						head_tag_q  <= tag_c[0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.head_time = head_time_q;
	assign rsp.head_tag  = head_tag_q;
	assign rsp.occupancy = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OCC_BITS'(CAPACITY))
		else $error("entry count above capacity");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + OCC_BITS'(1))
		else $error("insert did not advance the count");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= OCC_BITS'(2) |-> time_c[0] <= time_c[1])
		else $error("head entries out of order");

	a_dequeue_head: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.del |=> rsp.head_time == $past(time_c[0]) && rsp.status == teq_pkg::ST_OK)
		else $error("dequeue returned wrong head");

endmodule

FILE: bench/tb_time_ordered_event_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_time_ordered_event_queue
// Drives enqueue, dequeue, peek and unused request words into the queue under
// several idle and stall mixes. A scoreboard keeps its own sorted copy of the
// queue and checks every response word field by field, in order.
// ----------------------------------------------------------------------------
module tb_time_ordered_event_queue;

	localparam int CAP = teq_pkg::CAPACITY_DEF;
	localparam int TW  = teq_pkg::TIME_BITS_DEF;
	localparam int GW  = teq_pkg::TAG_BITS_DEF;
	localparam int OW  = $clog2(CAP + 1);
	localparam int AW  = teq_pkg::ACTION_BITS;

	localparam logic [AW-1:0] ACT_UNUSED = 2'd3;

	localparam int PHASE_ITEMS  = 106;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [teq_pkg::STATUS_BITS-1:0] status;
		logic [TW-1:0]                   head_time;
		logic [GW-1:0]                   head_tag;
		logic [OW-1:0]                   occupancy;
	} result_t;

	class event_queue_scoreboard;
		logic [TW-1:0] held_time[$];
		logic [GW-1:0] held_tag[$];
		result_t       pending[$];
		int            errors;

		function void note_request(logic [AW-1:0] action, logic [TW-1:0] t,
				logic [GW-1:0] g);
			result_t r;
			int      pos;
			int      i;
			r = '0;
			r.status = teq_pkg::ST_OK;
			case (action)
				teq_pkg::ACT_ENQUEUE: begin
					if (held_time.size() >= CAP) begin
						r.status = teq_pkg::ST_FULL;
					end else begin
						pos = held_time.size();
						for (i = 0; i < held_time.size(); i++) begin
							if (t < held_time[i]) begin
								pos = i;
								break;
							end
						end
						held_time.insert(pos, t);
						held_tag.insert(pos, g);
					end
				end
				teq_pkg::ACT_DEQUEUE, teq_pkg::ACT_PEEK: begin
					if (held_time.size() == 0) begin
						r.status = teq_pkg::ST_EMPTY;
					end else begin
						r.head_time = held_time[0];
						r.head_tag  = held_tag[0];
						if (action == teq_pkg::ACT_DEQUEUE) begin
							void'(held_time.pop_front());
							void'(held_tag.pop_front());
						end
					end
				end
				default: ;
			endcase
			r.occupancy = OW'(held_time.size());
			pending.push_back(r);
		endfunction

		function void check_response(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$error("unexpected word: status %0d head_time %0h head_tag %0h occupancy %0d",
					got.status, got.head_time, got.head_tag, got.occupancy);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.head_time !== want.head_time) begin
				$error("head_time: expected %0h, actual %0h", want.head_time, got.head_time);
				errors++;
			end
			if (got.head_tag !== want.head_tag) begin
				$error("head_tag: expected %0h, actual %0h", want.head_tag, got.head_tag);
				errors++;
			end
			if (got.occupancy !== want.occupancy) begin
				$error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	teq_req_if req_ch ();
	teq_rsp_if rsp_ch ();

	time_ordered_event_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	event_queue_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	int plan_occ;
	int idle_cycles;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			idle_cycles++;
			if (req_ch.valid && req_ch.ready) begin
				sb.note_request(req_ch.action, req_ch.event_time, req_ch.event_tag);
				idle_cycles = 0;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status    = rsp_ch.status;
				got.head_time = rsp_ch.head_time;
				got.head_tag  = rsp_ch.head_tag;
				got.occupancy = rsp_ch.occupancy;
				sb.check_response(got);
				idle_cycles = 0;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_time_ordered_event_queue: done, errors");
				$finish;
			end
		end else begin
			idle_cycles = 0;
		end
	end

	task automatic send_word(logic [AW-1:0] action, logic [TW-1:0] t,
			logic [GW-1:0] g);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.action     <= action;
		req_ch.event_time <= t;
		req_ch.event_tag  <= g;
		do @(posedge clk); while (!req_ch.ready);
		if (action == teq_pkg::ACT_ENQUEUE && plan_occ < CAP)
			plan_occ++;
		else if (action == teq_pkg::ACT_DEQUEUE && plan_occ > 0)
			plan_occ--;
	endtask

	initial begin
		int            phase;
		int            n;
		int            k;
		int            roll;
		bit            filling;
		logic [AW-1:0] act;
		logic [TW-1:0] t;
		logic [GW-1:0] g;

		sb = new;
		clk = 1'b0;
		arst_n = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		plan_occ = 0;
		req_ch.valid      <= 1'b0;
		req_ch.action     <= teq_pkg::ACT_ENQUEUE;
		req_ch.event_time <= '0;
		req_ch.event_tag  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(teq_pkg::ACT_DEQUEUE, '1, '1);
		send_word(teq_pkg::ACT_PEEK, '0, '0);
		send_word(ACT_UNUSED, '1, '1);
		send_word(teq_pkg::ACT_ENQUEUE, '1, '1);
		send_word(teq_pkg::ACT_ENQUEUE, '0, '0);
		send_word(teq_pkg::ACT_ENQUEUE, 100, 16'h00a1);
		send_word(teq_pkg::ACT_ENQUEUE, 100, 16'h00a2);
		send_word(teq_pkg::ACT_ENQUEUE, 100, 16'h00a3);
		send_word(teq_pkg::ACT_ENQUEUE, 50, 16'h0050);
		send_word(teq_pkg::ACT_PEEK, '0, '0);
		send_word(teq_pkg::ACT_DEQUEUE, '0, '0);
		for (k = 0; k < 11; k++) begin
			case (k % 3)
				0: t = 100;
				1: t = '1;
				default: t = TW'(k);
			endcase
			send_word(teq_pkg::ACT_ENQUEUE, t, GW'(16'h0100 + k));
		end
		send_word(teq_pkg::ACT_ENQUEUE, 1, 16'h5555);
		send_word(ACT_UNUSED, '0, '0);
		send_word(teq_pkg::ACT_PEEK, '1, '1);

		filling = 1'b0;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 88; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 88; end
				default: begin send_idle_pct = 6; stall_pct = 6; end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (plan_occ == CAP && $urandom_range(0, 3) == 0)
					filling = 1'b0;
				else if (plan_occ == 0 && $urandom_range(0, 3) == 0)
					filling = 1'b1;
				else if ($urandom_range(0, 39) == 0)
					filling = !filling;

				roll = $urandom_range(0, 99);
				if (roll < (filling ? 70 : 20))
					act = teq_pkg::ACT_ENQUEUE;
				else if (roll < (filling ? 85 : 80))
					act = teq_pkg::ACT_DEQUEUE;
				else if (roll < 95)
					act = teq_pkg::ACT_PEEK;
				else
					act = ACT_UNUSED;

				roll = $urandom_range(0, 99);
				if (roll < 40) begin
					t = TW'($urandom_range(0, 7));
				end else if (roll < 50) begin
					case ($urandom_range(0, 3))
						0: t = '0;
						1: t = '1;
						2: t = {1'b1, {(TW-1){1'b0}}};
						default: t = {1'b0, {(TW-1){1'b1}}};
					endcase
				end else begin
					t = TW'($urandom);
				end
				g = ($urandom_range(0, 15) == 0) ? '1 : GW'($urandom_range(0, 65535));
				send_word(act, t, g);
			end
		end
		req_ch.valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_time_ordered_event_queue: done, clean");
		else
			$display("tb_time_ordered_event_queue: done, errors");
		$finish;
	end

endmodule

FILE: sim.f
design/teq_pkg.sv
design/teq_if.sv
design/teq_cell.sv
design/time_ordered_event_queue.sv
bench/tb_time_ordered_event_queue.sv
